>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk outside reset.
`define PFCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check a property on every rising edge of aclk, reset included.
`define PFCE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> design/pfce_pkg.sv
`default_nettype none

package pfce_pkg;

    // Bus access transaction
    typedef struct packed {
        logic        op;
        logic [16:0] address;
        logic [1:0]  size_code;
        logic [7:0]  write_byte;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } out_item_t;

    // Access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE  = 2'd1;
    localparam logic [1:0] STATUS_UNLOCK    = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd3;

    // Store byte after erase
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Action requested by the command sequencer for one write
    typedef struct packed {
        logic [1:0] status;
        logic       prog;
        logic       erase;
    } seq_act_t;

endpackage

`default_nettype wire

>>> design/parallel_flash_command_engine.sv
// Byte-wide NOR flash behind a JEDEC-style command sequencer. An accepted bus access
// moves to a work state, which loads its result into the output register. A new access
// is only taken once the block is back in idle. While a result waits in the output
// register, the next access is held in its work cycle. The store is four byte banks
// with a registered read. A 1-, 2- or 4-byte read (wrapping at the end of the store)
// needs one bank read. A program byte is a registered read, then an AND write-back in
// the work state. A sector erase (AA/55/80/AA/55/30) returns its result and then walks
// min(SECTOR_BYTES, FLASH_BYTES)/4 rows, one per cycle. No access is taken during the
// walk. Reset does not clear the store; it holds a preloaded image, and reading a byte
// that was never written gives an undefined value.
`default_nettype none

module parallel_flash_command_engine #(
    parameter int FLASH_BYTES  = 131072,
    parameter int SECTOR_BYTES = 16384
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pfce_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pfce_pkg::out_item_t      m_data
);

    import pfce_pkg::*;

    localparam int AW          = $clog2(FLASH_BYTES);
    localparam int RW          = AW - 2;
    localparam int ROWS        = FLASH_BYTES / 4;
    localparam int ERASE_BYTES = (SECTOR_BYTES < FLASH_BYTES) ? SECTOR_BYTES : FLASH_BYTES;
    localparam int ERASE_ROWS  = ERASE_BYTES / 4;
    localparam int EW          = $clog2(ERASE_ROWS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WORK  = 2'd1;
    localparam logic [1:0] ST_ERASE = 2'd2;

    logic [1:0]    state_reg, state_next;
    in_item_t      item_reg;
    logic [EW-1:0] ers_cnt_reg, ers_cnt_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    logic          accept;
    logic          slot_free;
    logic [31:0]   s_addr_ext;
    logic [AW-1:0] s_addr;
    logic [31:0]   item_addr_ext;
    logic [AW-1:0] item_addr;
    logic [RW-1:0] item_row;
    logic [RW-1:0] erase_row;
    logic          step_en;
    seq_act_t      act;
    logic [31:0]   rd_word;
    logic [31:0]   rd_mask;

    logic [RW-1:0] rd_row  [4];
    logic [7:0]    rd_q    [4];
    logic          wr_en   [4];
    logic [RW-1:0] wr_row  [4];
    logic [7:0]    wr_data [4];

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign slot_free = !m_valid_reg || m_ready;

    // Mask incoming and held addresses to the store size
    assign s_addr_ext    = 32'(s_data.address);
    assign s_addr        = s_addr_ext[AW-1:0];
    assign item_addr_ext = 32'(item_reg.address);
    assign item_addr     = item_addr_ext[AW-1:0];
    assign item_row      = item_addr[AW-1:2];
    assign erase_row     = (item_row & ~RW'(ERASE_ROWS - 1)) | RW'(ers_cnt_reg);

    // Sequencer steps once per write, when the result can be loaded
    assign step_en = (state_reg == ST_WORK) && slot_free && (item_reg.op == OP_WRITE);

    pfce_seq #(
        .AW (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .addr      (item_addr),
        .size_code (item_reg.size_code),
        .wr_byte   (item_reg.write_byte),
        .act       (act)
    );

    // Bank ports: bank b holds byte addresses with low bits equal to b
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]    off;
        logic [AW-1:0] baddr;

        assign off        = 2'(b) - s_addr[1:0];
        assign baddr      = s_addr + AW'(off);
        assign rd_row[b]  = baddr[AW-1:2];
        assign wr_row[b]  = (state_reg == ST_ERASE) ? erase_row : item_row;
        assign wr_data[b] = (state_reg == ST_ERASE) ? ERASED_BYTE
                                                   : (rd_q[b] & item_reg.write_byte);
        assign wr_en[b]   = (state_reg == ST_ERASE)
                         || (act.prog && (item_addr[1:0] == 2'(b)));

        pfce_bank #(
            .DEPTH (ROWS),
            .RW    (RW)
        ) u_bank (
            .aclk    (aclk),
            .rd_en   (accept),
            .rd_row  (rd_row[b]),
            .rd_data (rd_q[b]),
            .wr_en   (wr_en[b]),
            .wr_row  (wr_row[b]),
            .wr_data (wr_data[b])
        );
    end

    // Gather read bytes little-endian from the banks
    always_comb begin
        rd_word = {rd_q[2'(item_addr[1:0] + 2'd3)], rd_q[2'(item_addr[1:0] + 2'd2)],
                   rd_q[2'(item_addr[1:0] + 2'd1)], rd_q[item_addr[1:0]]};
        case (item_reg.size_code)
            SIZE_BYTE: rd_mask = 32'h0000_00FF;
            SIZE_HALF: rd_mask = 32'h0000_FFFF;
            SIZE_WORD: rd_mask = 32'hFFFF_FFFF;
            default:   rd_mask = 32'h0000_0000;
        endcase
    end

    // Control and result register
    always_comb begin
        state_next   = state_reg;
        ers_cnt_next = ers_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (item_reg.op == OP_READ) begin
                        m_data_next.read_data = rd_word & rd_mask;
                        m_data_next.status    = (item_reg.size_code == SIZE_BAD)
                                                ? STATUS_BAD_SIZE : STATUS_OK;
                        state_next            = ST_IDLE;
                    end else begin
                        m_data_next.read_data = '0;
                        m_data_next.status    = act.status;
                        state_next            = act.erase ? ST_ERASE : ST_IDLE;
                    end
                end
            end
            ST_ERASE: begin
                if (ers_cnt_reg == EW'(ERASE_ROWS - 1)) begin
                    ers_cnt_next = '0;
                    state_next   = ST_IDLE;
                end else begin
                    ers_cnt_next = ers_cnt_reg + EW'(1);
                end
            end
            default: begin
                state_next   = ST_IDLE;
                ers_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ers_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ers_cnt_reg <= ers_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the accepted transaction and the result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "assert_macros.svh"

    `PFCE_ASSERT(a_accept_to_work,
        accept |=> (state_reg == ST_WORK),
        "accept did not start work")
    `PFCE_ASSERT(a_cnt_idle,
        (state_reg != ST_ERASE) |-> (ers_cnt_reg == '0),
        "erase count not clear")
    `PFCE_ASSERT(a_wr_phase,
        (wr_en[0] || wr_en[1] || wr_en[2] || wr_en[3])
            |-> (state_reg == ST_WORK || state_reg == ST_ERASE),
        "store write outside work")
    `PFCE_ASSERT(a_result_from_work,
        (m_valid_reg && !$past(m_valid_reg)) |-> ($past(state_reg) == ST_WORK),
        "result not from work")

endmodule

`default_nettype wire

>>> design/pfce_bank.sv
`default_nettype none

module pfce_bank #(
    parameter int DEPTH = 32768,
    parameter int RW    = 15
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [RW-1:0] rd_row,
    output logic [7:0]         rd_data,
    input  wire logic          wr_en,
    input  wire logic [RW-1:0] wr_row,
    input  wire logic [7:0]    wr_data
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_row] <= wr_data;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/pfce_seq.sv
`default_nettype none

module pfce_seq #(
    parameter int AW = 17
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire logic [AW-1:0] addr,
    input  wire logic [1:0]    size_code,
    input  wire logic [7:0]    wr_byte,
    output pfce_pkg::seq_act_t act
);

    import pfce_pkg::*;

    localparam logic [2:0] SQ_CMD_AA = 3'd0;
    localparam logic [2:0] SQ_CMD_55 = 3'd1;
    localparam logic [2:0] SQ_CMD    = 3'd2;
    localparam logic [2:0] SQ_ER_AA  = 3'd3;
    localparam logic [2:0] SQ_ER_55  = 3'd4;
    localparam logic [2:0] SQ_ER     = 3'd5;
    localparam logic [2:0] SQ_PROG   = 3'd6;

    localparam logic [AW-1:0] UNLOCK_ADDR1  = AW'(32'h5555);
    localparam logic [AW-1:0] UNLOCK_ADDR2A = AW'(32'hAAAA);
    localparam logic [AW-1:0] UNLOCK_ADDR2B = AW'(32'h2AAA);

    localparam logic [7:0] UNLOCK_BYTE1 = 8'hAA;
    localparam logic [7:0] UNLOCK_BYTE2 = 8'h55;
    localparam logic [7:0] CMD_PROGRAM  = 8'hA0;
    localparam logic [7:0] CMD_ERASE    = 8'h80;
    localparam logic [7:0] CMD_SECTOR   = 8'h30;

    logic [2:0] seq_reg;
    logic [2:0] seq_next;
    logic [2:0] cur;
    seq_act_t   act_c;

    // Decode one write against the sequencer state
    always_comb begin
        cur      = (seq_reg > SQ_PROG) ? SQ_CMD_AA : seq_reg;
        seq_next = seq_reg;
        act_c    = '0;
        if (step_en) begin
            if (size_code != SIZE_BYTE) begin
                act_c.status = STATUS_BAD_SIZE;
                seq_next     = SQ_CMD_AA;
            end else begin
                case (cur)
                    SQ_CMD_AA, SQ_ER_AA: begin
                        if (addr == UNLOCK_ADDR1 && wr_byte == UNLOCK_BYTE1) begin
                            seq_next = cur + 3'd1;
                        end else begin
                            seq_next     = SQ_CMD_AA;
                            act_c.status = STATUS_UNLOCK;
                        end
                    end
                    SQ_CMD_55, SQ_ER_55: begin
                        if ((addr == UNLOCK_ADDR2A || addr == UNLOCK_ADDR2B)
                                && wr_byte == UNLOCK_BYTE2) begin
                            seq_next = cur + 3'd1;
                        end else begin
                            seq_next     = SQ_CMD_AA;
                            act_c.status = STATUS_UNLOCK;
                        end
                    end
                    SQ_CMD: begin
                        if (wr_byte == CMD_PROGRAM) begin
                            seq_next = SQ_PROG;
                        end else if (wr_byte == CMD_ERASE) begin
                            seq_next = SQ_ER_AA;
                        end else begin
                            seq_next     = SQ_CMD_AA;
                            act_c.status = STATUS_UNKNOWN;
                        end
                    end
                    SQ_ER: begin
                        if (wr_byte == CMD_SECTOR) begin
                            act_c.erase = 1'b1;
                        end else begin
                            act_c.status = STATUS_UNKNOWN;
                        end
                        seq_next = SQ_CMD_AA;
                    end
                    SQ_PROG: begin
                        act_c.prog = 1'b1;
                        seq_next   = SQ_CMD_AA;
                    end
                    default: begin
                        seq_next = SQ_CMD_AA;
                    end
                endcase
            end
        end
    end

    // Advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= SQ_CMD_AA;
        end else begin
            seq_reg <= seq_next;
        end
    end

    assign act = act_c;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pfce_pkg::*;

    localparam int FLASH_BYTES      = 131072;
    localparam int SECTOR_BYTES     = 16384;
    localparam int SECTOR_COUNT     = FLASH_BYTES / SECTOR_BYTES;
    localparam int SECTOR_SHIFT     = 14;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_CYCLES  = 20000;
    localparam int SETTLE_CYCLES    = 16;

    localparam logic [16:0] UNLOCK_ADDR_FIRST = 17'h05555;
    localparam logic [16:0] UNLOCK_ADDR_HIGH  = 17'h0AAAA;
    localparam logic [16:0] UNLOCK_ADDR_LOW   = 17'h02AAA;
    localparam logic [7:0]  UNLOCK_BYTE_FIRST  = 8'hAA;
    localparam logic [7:0]  UNLOCK_BYTE_SECOND = 8'h55;
    localparam logic [7:0]  CMD_PROGRAM        = 8'hA0;
    localparam logic [7:0]  CMD_ERASE          = 8'h80;
    localparam logic [7:0]  CMD_SECTOR_ERASE   = 8'h30;
    localparam logic [7:0]  CMD_NONE           = 8'h00;

    typedef enum logic [2:0] {
        SEQ_WAIT_AA,
        SEQ_WAIT_55,
        SEQ_WAIT_CMD,
        SEQ_ERASE_WAIT_AA,
        SEQ_ERASE_WAIT_55,
        SEQ_ERASE_WAIT_30,
        SEQ_WAIT_PROGRAM
    } seq_phase_e;

    typedef in_item_t access_list_t[$];

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Flash image and sequencer as the testbench sees them
    logic [7:0]  flash_image [FLASH_BYTES];
    bit          sector_erased [SECTOR_COUNT];
    seq_phase_e  seq_phase = SEQ_WAIT_AA;
    logic [16:0] last_programmed_addr = '0;

    out_item_t   predicted_bus_results[$];
    int unsigned accesses_sent = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;
    bit          idle_on       = 1'b1;
    bit          hold_results  = 1'b0;

    parallel_flash_command_engine #(
        .FLASH_BYTES  (FLASH_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Advance the flash image and sequencer by one bus transaction
    function automatic out_item_t predict_bus_access(input in_item_t acc);
        out_item_t   res;
        logic [16:0] idx;
        logic [16:0] base;
        int unsigned n;
        res = '0;
        if (acc.op == OP_READ) begin
            if (acc.size_code == SIZE_BAD) begin
                res.status = STATUS_BAD_SIZE;
            end else begin
                n = 1 << acc.size_code;
                for (int i = 0; i < n; i++) begin
                    idx = acc.address + 17'(i);
                    res.read_data[8*i +: 8] = flash_image[idx];
                end
            end
        end else if (acc.size_code != SIZE_BYTE) begin
            seq_phase  = SEQ_WAIT_AA;
            res.status = STATUS_BAD_SIZE;
        end else begin
            case (seq_phase)
                SEQ_WAIT_AA, SEQ_ERASE_WAIT_AA: begin
                    if (acc.address == UNLOCK_ADDR_FIRST && acc.write_byte == UNLOCK_BYTE_FIRST)
                        seq_phase = (seq_phase == SEQ_WAIT_AA) ? SEQ_WAIT_55 : SEQ_ERASE_WAIT_55;
                    else begin
                        seq_phase  = SEQ_WAIT_AA;
                        res.status = STATUS_UNLOCK;
                    end
                end
                SEQ_WAIT_55, SEQ_ERASE_WAIT_55: begin
                    if ((acc.address == UNLOCK_ADDR_HIGH || acc.address == UNLOCK_ADDR_LOW)
                            && acc.write_byte == UNLOCK_BYTE_SECOND)
                        seq_phase = (seq_phase == SEQ_WAIT_55) ? SEQ_WAIT_CMD : SEQ_ERASE_WAIT_30;
                    else begin
                        seq_phase  = SEQ_WAIT_AA;
                        res.status = STATUS_UNLOCK;
                    end
                end
                SEQ_WAIT_CMD: begin
                    if (acc.write_byte == CMD_PROGRAM) begin
                        seq_phase = SEQ_WAIT_PROGRAM;
                    end else if (acc.write_byte == CMD_ERASE) begin
                        seq_phase = SEQ_ERASE_WAIT_AA;
                    end else begin
                        seq_phase  = SEQ_WAIT_AA;
                        res.status = STATUS_UNKNOWN;
                    end
                end
                SEQ_ERASE_WAIT_30: begin
                    if (acc.write_byte == CMD_SECTOR_ERASE) begin
                        base = {acc.address[16:SECTOR_SHIFT], {SECTOR_SHIFT{1'b0}}};
                        for (int i = 0; i < SECTOR_BYTES; i++)
                            flash_image[base + 17'(i)] = ERASED_BYTE;
                        sector_erased[acc.address[16:SECTOR_SHIFT]] = 1'b1;
                    end else begin
                        res.status = STATUS_UNKNOWN;
                    end
                    seq_phase = SEQ_WAIT_AA;
                end
                default: begin
                    flash_image[acc.address] = flash_image[acc.address] & acc.write_byte;
                    last_programmed_addr     = acc.address;
                    seq_phase                = SEQ_WAIT_AA;
                end
            endcase
        end
        return res;
    endfunction

    function automatic bit bytes_erased(input logic [16:0] addr, input int unsigned n);
        logic [16:0] idx;
        for (int i = 0; i < n; i++) begin
            idx = addr + 17'(i);
            if (!sector_erased[idx[16:SECTOR_SHIFT]])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Pick an address whose n bytes all lie in an erased sector
    function automatic logic [16:0] erased_address(input int unsigned n);
        int unsigned sect;
        int unsigned offset;
        do sect = $urandom_range(0, SECTOR_COUNT - 1); while (!sector_erased[sect]);
        case ($urandom_range(0, 3))
            0:       offset = 0;
            1:       offset = SECTOR_BYTES - n;
            default: offset = $urandom_range(0, SECTOR_BYTES - n);
        endcase
        return 17'(sect * SECTOR_BYTES + offset);
    endfunction

    // Steer reads and program bytes away from bytes that hold no defined value
    function automatic in_item_t steer_to_erased(input in_item_t acc);
        int unsigned n;
        if (acc.op == OP_READ && acc.size_code != SIZE_BAD) begin
            n = 1 << acc.size_code;
            if (!bytes_erased(acc.address, n))
                acc.address = erased_address(n);
        end else if (acc.op == OP_WRITE && acc.size_code == SIZE_BYTE
                && seq_phase == SEQ_WAIT_PROGRAM && !bytes_erased(acc.address, 1)) begin
            acc.address = erased_address(1);
        end
        return acc;
    endfunction

    function automatic in_item_t write_access(input logic [16:0] a, input logic [7:0] b);
        return '{op: OP_WRITE, address: a, size_code: SIZE_BYTE, write_byte: b};
    endfunction

    function automatic in_item_t read_access(input logic [16:0] a, input logic [1:0] sz);
        return '{op: OP_READ, address: a, size_code: sz, write_byte: 8'($urandom)};
    endfunction

    function automatic in_item_t random_access();
        return '{op: 1'($urandom), address: 17'($urandom), size_code: 2'($urandom),
                 write_byte: 8'($urandom)};
    endfunction

    function automatic logic [16:0] second_unlock_addr();
        return $urandom_range(0, 1) ? UNLOCK_ADDR_HIGH : UNLOCK_ADDR_LOW;
    endfunction

    function automatic access_list_t program_steps(input logic [16:0] a, input logic [7:0] b);
        access_list_t steps;
        steps.push_back(write_access(UNLOCK_ADDR_FIRST, UNLOCK_BYTE_FIRST));
        steps.push_back(write_access(second_unlock_addr(), UNLOCK_BYTE_SECOND));
        steps.push_back(write_access(17'($urandom), CMD_PROGRAM));
        steps.push_back(write_access(a, b));
        return steps;
    endfunction

    function automatic access_list_t erase_steps(input logic [16:0] a, input logic [7:0] confirm);
        access_list_t steps;
        steps.push_back(write_access(UNLOCK_ADDR_FIRST, UNLOCK_BYTE_FIRST));
        steps.push_back(write_access(second_unlock_addr(), UNLOCK_BYTE_SECOND));
        steps.push_back(write_access(17'($urandom), CMD_ERASE));
        steps.push_back(write_access(UNLOCK_ADDR_FIRST, UNLOCK_BYTE_FIRST));
        steps.push_back(write_access(second_unlock_addr(), UNLOCK_BYTE_SECOND));
        steps.push_back(write_access(a, confirm));
        return steps;
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic send_access(input in_item_t acc);
        int unsigned gap;
        acc = steer_to_erased(acc);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= acc;
        do @(posedge aclk); while (!s_ready);
        predicted_bus_results.push_back(predict_bus_access(acc));
        accesses_sent++;
    endtask

    // Send a command chain, optionally with one step replaced by noise
    task automatic send_steps(input access_list_t steps, input bit corrupt);
        if (corrupt)
            steps[$urandom_range(0, steps.size() - 1)] = random_access();
        foreach (steps[i])
            send_access(steps[i]);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (predicted_bus_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_sector_erase();
        send_steps(erase_steps(17'h1FFFF, CMD_SECTOR_ERASE), 1'b0);
        send_steps(erase_steps(17'h00000, CMD_SECTOR_ERASE), 1'b0);
    endtask

    task automatic test_wrapping_reads();
        send_access(read_access(17'h1FFFE, SIZE_WORD));
        send_access(read_access(17'h1FFFF, SIZE_HALF));
        send_access(read_access(17'h00000, SIZE_BYTE));
        send_access(read_access(UNLOCK_ADDR_HIGH, SIZE_BAD));
    endtask

    task automatic test_program_byte();
        send_steps(program_steps(17'h1FFFF, 8'h5A), 1'b0);
        send_access(read_access(17'h1FFFE, SIZE_WORD));
    endtask

    task automatic test_sequencer_errors();
        in_item_t wide;
        // wide write, then a wrong unlock byte
        wide = write_access(UNLOCK_ADDR_FIRST, UNLOCK_BYTE_FIRST);
        wide.size_code = SIZE_WORD;
        send_access(wide);
        send_access(write_access(UNLOCK_ADDR_FIRST, UNLOCK_BYTE_SECOND));
        // unknown command after a good unlock
        send_access(write_access(UNLOCK_ADDR_FIRST, UNLOCK_BYTE_FIRST));
        send_access(write_access(UNLOCK_ADDR_LOW, UNLOCK_BYTE_SECOND));
        send_access(write_access(17'h1FFFF, CMD_NONE));
        // erase chain closed by something other than the sector erase byte
        send_steps(erase_steps(17'h04000, ERASED_BYTE), 1'b0);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        target = accesses_sent + count;
        while (accesses_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_steps(erase_steps(17'($urandom), CMD_SECTOR_ERASE),
                           $urandom_range(0, 7) == 0);
            end else if (pick < 45) begin
                send_steps(program_steps(17'($urandom), 8'($urandom)),
                           $urandom_range(0, 5) == 0);
                if ($urandom_range(0, 1))
                    send_access(read_access(last_programmed_addr, 2'($urandom_range(0, 2))));
            end else if (pick < 80) begin
                send_access(read_access(17'($urandom), 2'($urandom)));
            end else begin
                send_access(random_access());
            end
        end
    endtask

    // Stall the result side long enough for the block to back up into its input
    task automatic test_result_backpressure();
        hold_results = 1'b1;
        repeat (24)
            send_access(read_access(17'($urandom), 2'($urandom)));
        wait_for_results();
    endtask

    task automatic test_idle_pause();
        wait_for_results();
        test_random_traffic(20);
    endtask

    // Accept results, with random stalls and one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 8);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        out_item_t expected;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_bus_results.size() == 0) begin
                $error("unexpected result: read_data %h status %0d", m_data.read_data,
                       m_data.status);
                error_count++;
            end else begin
                expected = predicted_bus_results.pop_front();
                if (m_data.read_data !== expected.read_data) begin
                    $error("read_data: expected %h, got %h", expected.read_data,
                           m_data.read_data);
                    error_count++;
                end
                if (m_data.status !== expected.status) begin
                    $error("status: expected %0d, got %0d", expected.status, m_data.status);
                    error_count++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("parallel_flash_command_engine test failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_sector_erase();
        test_wrapping_reads();
        test_program_byte();
        test_sequencer_errors();
        test_random_traffic(230);
        test_idle_pause();
        test_result_backpressure();
        test_random_traffic(130);
        idle_on = 1'b0;
        test_random_traffic(100);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("parallel_flash_command_engine test passed");
        else
            $display("parallel_flash_command_engine test failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+design
design/pfce_pkg.sv
design/pfce_bank.sv
design/pfce_seq.sv
design/parallel_flash_command_engine.sv
dv/testbench.sv
